// ===== rtl/cfr_pkg.sv =====
// ----------------------------------------------------------------------------
// cfr_pkg: shared types and constants for the command frame receiver
// Frame codes, result status codes and the result record passed from the
// parser to the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

package cfr_pkg;

  localparam int unsigned DefaultMaxPayload = 49;

  localparam logic [7:0] HDR0          = 8'hAA;
  localparam logic [7:0] HDR1          = 8'hAF;
  localparam logic [7:0] FUNC_LIMIT    = 8'hF1;
  localparam logic [7:0] FUNC_PARAM_REQ = 8'h02;
  localparam logic [7:0] FUNC_GAIN_SET = 8'h10;

  localparam int unsigned CaptureDepth = 6;
  localparam int unsigned CapIdxW      = 3;
  localparam int unsigned GainCount    = 3;

  typedef enum logic [1:0] {
    STATUS_MISMATCH  = 2'd0,
    STATUS_PARAM_REQ = 2'd1,
    STATUS_GAIN_SET  = 2'd2,
    STATUS_OTHER     = 2'd3
  } status_t;

  typedef struct packed {
    logic               await_check;  // next byte is a checksum byte
    logic               valid;        // this byte completes a frame
    status_t            status;
    logic [7:0]         func_code;
    logic [7:0]         frame_sum;
    logic signed [15:0] gain_p;
    logic signed [15:0] gain_i;
    logic signed [15:0] gain_d;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/cfr_parser.sv =====
// ----------------------------------------------------------------------------
// cfr_parser: frame state machine, running sum, payload capture and gains
// Walks one byte per transfer through header, function, length, payload and
// checksum, and forms the frame result on the checksum byte.
// ----------------------------------------------------------------------------
`default_nettype none

module cfr_parser import cfr_pkg::*; #(
  parameter int unsigned MAX_PAYLOAD = DefaultMaxPayload
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       accept,
  input  wire logic [7:0] rx_byte,
  output result_t         res
);

  localparam int unsigned CntW = $clog2(MAX_PAYLOAD + 1);

  typedef enum logic [2:0] {
    HUNT0   = 3'd0,
    HUNT1   = 3'd1,
    FUNC    = 3'd2,
    LEN     = 3'd3,
    PAYLOAD = 3'd4,
    CHECK   = 3'd5
  } phase_t;

  phase_t            phase, phase_next;
  logic [CntW-1:0]   bytes_left, bytes_left_next;
  logic [CntW-1:0]   payload_count, payload_count_next;
  logic [7:0]        running_sum, running_sum_next;
  logic [7:0]        function_latch, function_latch_next;
  logic [7:0]        capture [CaptureDepth];
  logic [7:0]        capture_next [CaptureDepth];
  logic [15:0]       gains [GainCount];
  logic [15:0]       gains_next [GainCount];
  logic              cap_hit;
  logic [7:0]        sum_plus;

  assign cap_hit  = payload_count < CntW'(CaptureDepth);
  assign sum_plus = running_sum + rx_byte;

  always_comb begin
    phase_next          = phase;
    bytes_left_next     = bytes_left;
    payload_count_next  = payload_count;
    running_sum_next    = running_sum;
    function_latch_next = function_latch;
    capture_next        = capture;
    gains_next          = gains;
    res.valid           = 1'b0;
    res.status          = STATUS_MISMATCH;

    unique case (phase)
      HUNT0: begin
        if (rx_byte == HDR0) begin
          phase_next       = HUNT1;
          running_sum_next = rx_byte;
        end
      end
      HUNT1: begin
        if (rx_byte == HDR1) begin
          phase_next       = FUNC;
          running_sum_next = sum_plus;
        end else begin
          phase_next = HUNT0;
        end
      end
      FUNC: begin
        if (rx_byte < FUNC_LIMIT) begin
          phase_next          = LEN;
          function_latch_next = rx_byte;
          running_sum_next    = sum_plus;
        end else begin
          phase_next = HUNT0;
        end
      end
      LEN: begin
        if (rx_byte <= 8'(MAX_PAYLOAD)) begin
          phase_next         = PAYLOAD;
          bytes_left_next    = rx_byte[CntW-1:0];
          payload_count_next = '0;
          running_sum_next   = sum_plus;
        end else begin
          phase_next = HUNT0;
        end
      end
      PAYLOAD: begin
        if (bytes_left != '0) begin
          bytes_left_next    = bytes_left - 1'b1;
          payload_count_next = payload_count + 1'b1;
          running_sum_next   = sum_plus;
          if (cap_hit) begin
            capture_next[payload_count[CapIdxW-1:0]] = rx_byte;
          end
          if (bytes_left == CntW'(1)) begin
            phase_next = CHECK;
          end
        end else begin
          phase_next = HUNT0;
        end
      end
      CHECK: begin
        phase_next = HUNT0;
        res.valid  = 1'b1;
        // a short payload lets the checksum byte land in the capture
        if (cap_hit) begin
          capture_next[payload_count[CapIdxW-1:0]] = rx_byte;
        end
        priority if (running_sum != rx_byte) begin
          res.status = STATUS_MISMATCH;
        end else if (function_latch == FUNC_PARAM_REQ) begin
          res.status = STATUS_PARAM_REQ;
        end else if (function_latch == FUNC_GAIN_SET) begin
          res.status = STATUS_GAIN_SET;
          for (int g = 0; g < GainCount; g++) begin
            gains_next[g] = {capture_next[2*g], capture_next[2*g+1]};
          end
        end else begin
          res.status = STATUS_OTHER;
        end
      end
      default: begin
        phase_next = HUNT0;
      end
    endcase

    res.await_check = (phase == CHECK);
    res.func_code   = function_latch;
    res.frame_sum   = running_sum;
    res.gain_p      = gains_next[0];
    res.gain_i      = gains_next[1];
    res.gain_d      = gains_next[2];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= HUNT0;
      bytes_left     <= '0;
      payload_count  <= '0;
      running_sum    <= '0;
      function_latch <= '0;
      for (int k = 0; k < CaptureDepth; k++) capture[k] <= '0;
      for (int g = 0; g < GainCount; g++) gains[g] <= '0;
    end else if (accept) begin
      phase          <= phase_next;
      bytes_left     <= bytes_left_next;
      payload_count  <= payload_count_next;
      running_sum    <= running_sum_next;
      function_latch <= function_latch_next;
      capture        <= capture_next;
      gains          <= gains_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/command_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// command_frame_receiver: serial command frame parser with additive checksum
//
//   channel | dir | fields
//   s_*     | in  | tdata[7:0] rx_byte
//   m_*     | out | tuser[1:0] status; tdata: func_code, frame_sum,
//           |     |   gain_p, gain_i, gain_d (64 bits)
//
// One byte per cycle; the checksum byte's result appears in the output
// register on the following cycle. Parser state and the result register are
// the only storage, so any byte may follow in the next cycle.
// Input stalls only while a result waits unread and the next byte is a
// checksum byte. Synchronous reset clears parser state, capture and gains.
// ----------------------------------------------------------------------------
`default_nettype none

module command_frame_receiver import cfr_pkg::*; #(
  parameter int unsigned MAX_PAYLOAD = DefaultMaxPayload
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [63:0]      m_tdata,   // [7:0] func_code, [15:8] frame_sum,
                                      // [31:16] gain_p, [47:32] gain_i,
                                      // [63:48] gain_d
  output logic [1:0]       m_tuser    // [1:0] status
);

  result_t res;
  logic    accept;

  assign s_tready = !(m_tvalid && !m_tready && res.await_check);
  assign accept   = s_tvalid && s_tready;

  cfr_parser #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_parser (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .rx_byte(s_tdata),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept && res.valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // load the result register on the checksum transfer
  always_ff @(posedge clk) begin
    if (accept && res.valid) begin
      m_tuser <= res.status;
      m_tdata <= {res.gain_d, res.gain_i, res.gain_p, res.frame_sum, res.func_code};
    end
  end

endmodule

`default_nettype wire

// ===== rtl/cfr_checker.sv =====
// ----------------------------------------------------------------------------
// cfr_checker: port-level checks for the command frame receiver
// Watches the top level's ports and flags handshake breaches and results that break frame rules.
// ----------------------------------------------------------------------------
`default_nettype none

module cfr_checker import cfr_pkg::*; (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic [7:0]  s_tdata,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [63:0] m_tdata,
  input wire logic [1:0]  m_tuser
);

  logic        seen;
  logic [47:0] last_gains;

  // track gains of the last delivered result
  always_ff @(posedge clk) begin
    if (rst) begin
      seen       <= 1'b0;
      last_gains <= '0;
    end else if (m_tvalid && m_tready) begin
      seen       <= 1'b1;
      last_gains <= m_tdata[63:16];
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

  a_input_hold: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata))
    else $error("input byte changed while stalled");

  a_func_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[7:0] < FUNC_LIMIT)
    else $error("function code out of range");

  a_gains_kept: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && seen && m_tuser != STATUS_GAIN_SET |-> m_tdata[63:16] == last_gains)
    else $error("gains changed without a gain frame");

endmodule

bind command_frame_receiver cfr_checker u_cfr_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .s_tdata (s_tdata),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tuser (m_tuser)
);

`default_nettype wire
